@@ src/tnts_pkg.sv @@
// shared types and constants for the triplanar nearest-texel sampler
`default_nettype none

package tnts_pkg;

	// field widths fixed by the item formats
	localparam int BYTE_W  = 8;
	localparam int LADDR_W = 18;
	localparam int POS_W   = 32;
	localparam int NORM_W  = 16;
	localparam int FRAC_W  = 16;
	localparam int CFG_W   = 9;
	// side values come from 9-bit registers, so sides and offsets fit 9 bits
	localparam int SIDE_W  = 9;
	// padded row length, at most 3 * 511 + 3 rounded up
	localparam int ROW_W   = 11;
	// texel byte index before store wrap, below 2^20 for every side
	localparam int IDX_W   = 20;
	localparam int QUEUE_DEPTH = 4;

	// request codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic CFG_TEX_WIDTH  = 1'b0;
	localparam logic CFG_TEX_HEIGHT = 1'b1;

	// rows are padded to a multiple of 4 bytes
	localparam logic [ROW_W-1:0] ROW_ALIGN_MASK = ~ROW_W'(3);

	// projection plane picked from the dominant normal axis
	typedef enum logic [1:0] {
		PLANE_YZ,
		PLANE_XZ,
		PLANE_XY
	} plane_t;

	typedef struct packed {
		logic                     req_type;
		logic [LADDR_W-1:0]       load_addr;
		logic [BYTE_W-1:0]        load_byte;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  red;
		logic [BYTE_W-1:0]  green;
		logic [BYTE_W-1:0]  blue;
		logic [LADDR_W-1:0] byte_index;
	} out_t;

	// classified work handed from front to back
	typedef struct packed {
		logic              is_load;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] wbyte;
	} job_t;

endpackage

`default_nettype wire

@@ src/triplanar_nearest_texel_sampler_core.sv @@
// top level of the triplanar nearest-texel sampler
`default_nettype none

// Takes one item per cycle on in_data while in_stall is low, and returns one
// result per sample item on out_data; load items write one byte of the texture
// store and return nothing. A sample passes through 4 front stages (plane pick,
// scaling multiply, row multiply and add), then the 4-entry queue, then 5 back
// stages (reciprocal multiply, quotient multiply, wrap correction, store access,
// output register). The store is kept in three copies of STORE_BYTES bytes so
// that the three bytes of a texel are read in the same cycle; every load writes
// all three copies. The store has no reset and needs no clearing pass: load it
// before sampling. Sides are tex_width and tex_height, with 0 taken as 1 and
// values above MAX_SIDE taken as MAX_SIDE. Write the size registers only while
// no item is in flight.

module triplanar_nearest_texel_sampler_core #(
	parameter int MAX_SIDE    = 256,
	parameter int STORE_BYTES = 262144
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire tnts_pkg::in_t              in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output tnts_pkg::out_t                  out_data,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [tnts_pkg::CFG_W-1:0] cfg_wdata
);

	logic [tnts_pkg::CFG_W-1:0] tex_width_q, tex_height_q;

	logic           fq_valid, fq_ready;
	tnts_pkg::job_t fq_job;
	logic           qb_valid, qb_ready;
	tnts_pkg::job_t qb_job;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= tnts_pkg::CFG_W'(1);
			tex_height_q <= tnts_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tnts_pkg::CFG_TEX_WIDTH:  tex_width_q  <= cfg_wdata;
				tnts_pkg::CFG_TEX_HEIGHT: tex_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tnts_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.tex_width (tex_width_q),
		.tex_height(tex_height_q),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	tnts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_job),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_job)
	);

	tnts_back #(
		.STORE_BYTES(STORE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(qb_valid),
		.job_ready(qb_ready),
		.job      (qb_job),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// input stalls only when the queue is full
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> !fq_ready)
		else $error("input stalled while the queue had room");

	// a full queue that the back does not drain stays full
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!fq_ready && !qb_ready) |=> !fq_ready)
		else $error("queue lost an entry without a transfer to the back");

	// an empty queue never reports full
	a_empty_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		!qb_valid |-> fq_ready)
		else $error("queue empty and full at once");

endmodule

`default_nettype wire

@@ src/tnts_front.sv @@
// front end: accepts items, picks the plane, scales and forms the texel index
`default_nettype none

module tnts_front #(
	parameter int MAX_SIDE = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire tnts_pkg::in_t                 in_data,
	input  wire logic [tnts_pkg::CFG_W-1:0]    tex_width,
	input  wire logic [tnts_pkg::CFG_W-1:0]    tex_height,
	output logic                               job_valid,
	input  wire logic                          job_ready,
	output tnts_pkg::job_t                     job
);

	localparam logic [10:0] MAX_SIDE_C = 11'(MAX_SIDE);

	// magnitude of a signed normal component, -32768 gives 32768
	function automatic logic [16:0] mag17(input logic [15:0] n);
		logic [16:0] ext;
		begin
			ext = {n[15], n};
			mag17 = n[15] ? (17'd0 - ext) : ext;
		end
	endfunction

	// register value 0 acts as 1, above the limit acts as the limit
	function automatic logic [tnts_pkg::SIDE_W-1:0] clamp_side(
		input logic [tnts_pkg::CFG_W-1:0] s
	);
		begin
			if (s == '0) begin
				clamp_side = tnts_pkg::SIDE_W'(1);
			end else if (11'(s) > MAX_SIDE_C) begin
				clamp_side = MAX_SIDE_C[tnts_pkg::SIDE_W-1:0];
			end else begin
				clamp_side = tnts_pkg::SIDE_W'(s);
			end
		end
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	tnts_pkg::in_t in_s1;

	logic                                is_load_s2, is_load_s3;
	logic [tnts_pkg::LADDR_W-1:0]        laddr_s2, laddr_s3;
	logic [tnts_pkg::BYTE_W-1:0]         byte_s2, byte_s3;
	logic [tnts_pkg::FRAC_W-1:0]         fu_s2, fv_s2;
	logic [tnts_pkg::SIDE_W-1:0]         wm1_s2, hm1_s2, wm1_s3, hm1_s3;
	logic [tnts_pkg::SIDE_W-1:0]         px_s3, pyr_s3;
	tnts_pkg::job_t                      job_s4;

	logic [16:0]                         mag_x, mag_y, mag_z;
	tnts_pkg::plane_t                    plane;
	logic [tnts_pkg::FRAC_W-1:0]         frac_u, frac_v;
	logic [tnts_pkg::SIDE_W-1:0]         wm1, hm1;
	logic [24:0]                         prod_u, prod_v;
	logic [tnts_pkg::SIDE_W-1:0]         py;
	logic [tnts_pkg::ROW_W-1:0]          row;
	logic [tnts_pkg::IDX_W-1:0]          idx;

	// whole front moves together unless the last stage cannot enter the queue
	assign adv      = !v_s4 || job_ready;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1 classification: plane choice, fractions and clamped sides
	always_comb begin
		mag_x = mag17(in_s1.norm_x);
		mag_y = mag17(in_s1.norm_y);
		mag_z = mag17(in_s1.norm_z);
		priority if (mag_x >= mag_y && mag_x >= mag_z) begin
			plane = tnts_pkg::PLANE_YZ;
		end else if (mag_y >= mag_z) begin
			plane = tnts_pkg::PLANE_XZ;
		end else begin
			plane = tnts_pkg::PLANE_XY;
		end
		unique case (plane)
			tnts_pkg::PLANE_YZ: begin
				frac_u = in_s1.pos_y[tnts_pkg::FRAC_W-1:0];
				frac_v = in_s1.pos_z[tnts_pkg::FRAC_W-1:0];
			end
			tnts_pkg::PLANE_XZ: begin
				frac_u = in_s1.pos_x[tnts_pkg::FRAC_W-1:0];
				frac_v = in_s1.pos_z[tnts_pkg::FRAC_W-1:0];
			end
			default: begin
				frac_u = in_s1.pos_x[tnts_pkg::FRAC_W-1:0];
				frac_v = in_s1.pos_y[tnts_pkg::FRAC_W-1:0];
			end
		endcase
		wm1 = clamp_side(tex_width) - tnts_pkg::SIDE_W'(1);
		hm1 = clamp_side(tex_height) - tnts_pkg::SIDE_W'(1);
	end

	// stage 2 scaling by (size - 1), truncated
	assign prod_u = 25'(fu_s2) * 25'(wm1_s2);
	assign prod_v = 25'(fv_s2) * 25'(hm1_s2);

	// stage 3 row flip and padded byte address
	always_comb begin
		py  = hm1_s3 - pyr_s3;
		row = (tnts_pkg::ROW_W'(wm1_s3) * tnts_pkg::ROW_W'(3) + tnts_pkg::ROW_W'(6))
			& tnts_pkg::ROW_ALIGN_MASK;
		idx = tnts_pkg::IDX_W'(py) * tnts_pkg::IDX_W'(row)
			+ tnts_pkg::IDX_W'(px_s3) * tnts_pkg::IDX_W'(3);
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= in_data;

			is_load_s2 <= (in_s1.req_type == tnts_pkg::REQ_LOAD);
			laddr_s2   <= in_s1.load_addr;
			byte_s2    <= in_s1.load_byte;
			fu_s2      <= frac_u;
			fv_s2      <= frac_v;
			wm1_s2     <= wm1;
			hm1_s2     <= hm1;

			is_load_s3 <= is_load_s2;
			laddr_s3   <= laddr_s2;
			byte_s3    <= byte_s2;
			px_s3      <= prod_u[24:16];
			pyr_s3     <= prod_v[24:16];
			wm1_s3     <= wm1_s2;
			hm1_s3     <= hm1_s2;

			job_s4.is_load <= is_load_s3;
			job_s4.addr    <= is_load_s3 ? tnts_pkg::IDX_W'(laddr_s3) : idx;
			job_s4.wbyte   <= byte_s3;
		end
	end

	assign job_valid = v_s4;
	assign job       = job_s4;

endmodule

`default_nettype wire

@@ src/tnts_queue.sv @@
// short job queue between the front and the back
`default_nettype none

module tnts_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire tnts_pkg::job_t push_data,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output tnts_pkg::job_t      pop_data
);

	localparam int PW = $clog2(tnts_pkg::QUEUE_DEPTH);
	localparam int CNTW = $clog2(tnts_pkg::QUEUE_DEPTH + 1);

	tnts_pkg::job_t   entry_q [tnts_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNTW'(tnts_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tnts_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tnts_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ src/tnts_back.sv @@
// back end: wraps addresses into the store, writes loads and reads texels
`default_nettype none

module tnts_back #(
	parameter int STORE_BYTES = 262144
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	output logic                job_ready,
	input  wire tnts_pkg::job_t job,
	output logic                out_valid,
	input  wire logic           out_stall,
	output tnts_pkg::out_t      out_data
);

	localparam int AW    = $clog2(STORE_BYTES);
	localparam int RECIP = (2 ** tnts_pkg::IDX_W) / STORE_BYTES;
	localparam int RW    = $clog2(RECIP + 2);
	localparam int PW    = tnts_pkg::IDX_W + RW;
	localparam int CW    = ((AW > tnts_pkg::IDX_W) ? AW : tnts_pkg::IDX_W) + 1;
	localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
	localparam logic [CW-1:0] SIZE_C  = CW'(STORE_BYTES);
	localparam logic [AW:0]   SIZE_A  = (AW + 1)'(STORE_BYTES);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	tnts_pkg::job_t job_s1, job_s2, job_s3;
	logic [RW-1:0]  q_s2;
	logic [CW-1:0]  qs_s3;

	logic [AW-1:0]                  addr_s4 [3];
	logic                           is_load_s4;
	logic [tnts_pkg::BYTE_W-1:0]    wbyte_s4;
	logic [tnts_pkg::LADDR_W-1:0]   bidx_s4, bidx_s5;
	logic [tnts_pkg::BYTE_W-1:0]    rd_s5 [3];

	logic [PW-1:0] prod;
	logic [CW-1:0] qs, rem, rem0;
	logic [AW:0]   n1, n2;
	logic [AW-1:0] a0, a1, a2;

	// output register doubles as the memory read register
	assign adv       = !v_s5 || !out_stall;
	assign job_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && !is_load_s4;
		end
	end

	// quotient estimate by reciprocal, low by at most one
	assign prod = PW'(job_s1.addr) * PW'(RECIP_C);

	// quotient times store size
	assign qs = CW'(q_s2) * SIZE_C;

	// one correction, then the two following bytes wrap on their own
	always_comb begin
		rem  = CW'(job_s3.addr) - qs_s3;
		rem0 = (rem >= SIZE_C) ? (rem - SIZE_C) : rem;
		a0   = rem0[AW-1:0];
		n1   = (AW + 1)'(a0) + (AW + 1)'(1);
		n2   = (AW + 1)'(a0) + (AW + 1)'(2);
		a1   = (n1 >= SIZE_A) ? AW'(n1 - SIZE_A) : n1[AW-1:0];
		a2   = (n2 >= SIZE_A) ? AW'(n2 - SIZE_A) : n2[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1 <= job;

			job_s2 <= job_s1;
			q_s2   <= prod[PW-1:tnts_pkg::IDX_W];

			job_s3 <= job_s2;
			qs_s3  <= qs;

			addr_s4[0] <= a0;
			addr_s4[1] <= a1;
			addr_s4[2] <= a2;
			is_load_s4 <= job_s3.is_load;
			wbyte_s4   <= job_s3.wbyte;
			bidx_s4    <= job_s3.addr[tnts_pkg::LADDR_W-1:0];

			bidx_s5 <= bidx_s4;
		end
	end

	// three copies of the byte store, one read port each, all written by loads
	for (genvar k = 0; k < 3; k++) begin : g_lane
		logic [tnts_pkg::BYTE_W-1:0] store_mem [STORE_BYTES];

		always_ff @(posedge clk) begin
			if (adv && v_s4) begin
				if (is_load_s4) begin
					store_mem[addr_s4[0]] <= wbyte_s4;
				end else begin
					rd_s5[k] <= store_mem[addr_s4[k]];
				end
			end
		end
	end

	assign out_valid           = v_s5;
	assign out_data.blue       = rd_s5[0];
	assign out_data.green      = rd_s5[1];
	assign out_data.red        = rd_s5[2];
	assign out_data.byte_index = bidx_s5;

endmodule

`default_nettype wire
